// File: rtl/ows_pkg.sv
// Shared types and constants of the 1-Wire ROM search step unit.
`default_nettype none

package ows_pkg;

   // Default ROM length in bits.
   localparam int ROM_BITS_DEFAULT = 64;

   // Field widths.
   localparam int POS_W    = 7;
   localparam int DISC_W   = 8;
   localparam int STATUS_W = 3;
   localparam int ROM_ID_W = 64;

   // Operation codes of an input beat.
   localparam logic OP_START = 1'b0;
   localparam logic OP_BITS  = 1'b1;

   // The only reset/presence result that counts as normal.
   localparam logic [1:0] RESET_OK = 2'b01;

   // Position that closes a pass once it has been handled.
   localparam logic [POS_W-1:0] POS_LAST = 7'd1;

   // Discrepancy value held after reset (first pass).
   localparam logic [DISC_W-1:0] DISC_FIRST = 8'hFF;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_STARTED     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_CHOSEN      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DONE        = 3'd2;
   localparam logic [STATUS_W-1:0] ST_RESET_FAULT = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NO_RESPONSE = 3'd4;

   // One input beat.
   typedef struct packed {
      logic              op;
      logic [1:0]        reset_status;
      logic [DISC_W-1:0] last_discrepancy;
      logic              id_bit;
      logic              cmp_bit;
   } req_item_type;

   // One result beat.
   typedef struct packed {
      logic                write_bit;
      logic [STATUS_W-1:0] status;
      logic [POS_W-1:0]    next_discrepancy;
      logic [ROM_ID_W-1:0] rom_id;
   } rsp_item_type;

endpackage

`default_nettype wire

// File: rtl/ows_core.sv
// Search state registers and the per-beat bit decision logic.
`default_nettype none

module ows_core #(
   parameter int ROM_BITS = ows_pkg::ROM_BITS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 fire,
   input  wire ows_pkg::req_item_type item,
   output logic                      has_rsp,
   output ows_pkg::rsp_item_type     rsp
);
   import ows_pkg::*;

   logic [ROM_BITS-1:0] rom_ff, rom_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [DISC_W-1:0]   held_ff, held_in;
   logic [POS_W-1:0]    found_ff, found_in;
   logic                active_ff, active_in;

   logic                conflict;
   logic                take_one;
   logic                dir_bit;
   logic [ROM_BITS-1:0] rom_shifted;
   logic [POS_W-1:0]    found_upd;

   // Direction choice for the current position.
   assign conflict    = !item.id_bit && !item.cmp_bit;
   assign take_one    = conflict &&
                        ((held_ff > {1'b0, pos_ff}) ||
                         (rom_ff[0] && (held_ff != {1'b0, pos_ff})));
   assign dir_bit     = item.id_bit | take_one;
   assign rom_shifted = {dir_bit, rom_ff[ROM_BITS-1:1]};
   assign found_upd   = take_one ? pos_ff : found_ff;

   // Next state and result for the beat in the input register.
   always_comb begin
      rom_in    = rom_ff;
      pos_in    = pos_ff;
      held_in   = held_ff;
      found_in  = found_ff;
      active_in = active_ff;
      has_rsp   = 1'b0;
      rsp       = '0;
      if (fire) begin
         case (item.op)
            OP_START: begin
               has_rsp = 1'b1;
               if (item.reset_status != RESET_OK) begin
                  active_in  = 1'b0;
                  rsp.status = ST_RESET_FAULT;
               end else begin
                  active_in  = 1'b1;
                  pos_in     = POS_W'(ROM_BITS);
                  held_in    = item.last_discrepancy;
                  found_in   = '0;
                  rsp.status = ST_STARTED;
               end
            end
            OP_BITS: begin
               if (active_ff) begin
                  has_rsp = 1'b1;
                  if (item.id_bit && item.cmp_bit) begin
                     active_in  = 1'b0;
                     rsp.status = ST_NO_RESPONSE;
                  end else begin
                     rom_in        = rom_shifted;
                     pos_in        = pos_ff - POS_W'(1);
                     found_in      = found_upd;
                     rsp.write_bit = dir_bit;
                     if (pos_ff == POS_LAST) begin
                        active_in            = 1'b0;
                        rsp.status           = ST_DONE;
                        rsp.next_discrepancy = found_upd;
                        rsp.rom_id           = ROM_ID_W'(rom_shifted);
                     end else begin
                        rsp.status = ST_CHOSEN;
                     end
                  end
               end
            end
            default: begin
               has_rsp = 1'b0;
            end
         endcase
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rom_ff    <= '0;
         pos_ff    <= POS_W'(ROM_BITS);
         held_ff   <= DISC_FIRST;
         found_ff  <= '0;
         active_ff <= 1'b0;
      end else begin
         rom_ff    <= rom_in;
         pos_ff    <= pos_in;
         held_ff   <= held_in;
         found_ff  <= found_in;
         active_ff <= active_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/onewire_rom_search_step_unit.sv
// Top level of the 1-Wire ROM search step unit.
// Usage: a start beat (req_op = 0) opens a search pass with the bus
// reset result and the discrepancy position of the previous pass. Each
// following beat (req_op = 1) carries the two read slots of one ROM bit
// and returns the direction bit to write back. The last bit of a pass
// also returns the assembled ROM and the next discrepancy position.
// A bit beat with no pass open is consumed and gives no result beat.
// Flow: a beat accepted into the input register is decided there by the
// core when the result register can take it, and its result is
// registered and offered on the rsp_ ports. Throughput: one beat per
// cycle while no result waits under rsp_stall; the decision is a few gates
// on the search state registers, which are updated in the same cycle.
// Stall: while a result waits under rsp_stall, one more beat is taken
// into the input register; req_stall rises only when both are full.
// Reset: synchronous; clears the valid flags of both registers and restarts
// the search state as for the first pass, with no pass open.
`default_nettype none

module onewire_rom_search_step_unit #(
   parameter int ROM_BITS = ows_pkg::ROM_BITS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_op,
   input  wire logic [1:0]                    req_reset_status,
   input  wire logic [ows_pkg::DISC_W-1:0]    req_last_discrepancy,
   input  wire logic                          req_id_bit,
   input  wire logic                          req_cmp_bit,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_write_bit,
   output logic [ows_pkg::STATUS_W-1:0]       rsp_status,
   output logic [ows_pkg::POS_W-1:0]          rsp_next_discrepancy,
   output logic [ows_pkg::ROM_ID_W-1:0]       rsp_rom_id
);
   import ows_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;
   logic         req_take;
   logic         advance;
   logic         core_has_rsp;
   rsp_item_type core_rsp;

   // Handshake: the input register moves on when the result register is
   // empty or is being emptied in this cycle.
   assign advance   = in_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.op               <= req_op;
         in_item_ff.reset_status     <= req_reset_status;
         in_item_ff.last_discrepancy <= req_last_discrepancy;
         in_item_ff.id_bit           <= req_id_bit;
         in_item_ff.cmp_bit          <= req_cmp_bit;
      end
   end

   // Search state and bit decision.
   ows_core #(
      .ROM_BITS(ROM_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_item_ff),
      .has_rsp(core_has_rsp),
      .rsp    (core_rsp)
   );

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = core_has_rsp;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && core_has_rsp) begin
         rsp_item_ff <= core_rsp;
      end
   end

   // Result ports.
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_write_bit        = rsp_item_ff.write_bit;
   assign rsp_status           = rsp_item_ff.status;
   assign rsp_next_discrepancy = rsp_item_ff.next_discrepancy;
   assign rsp_rom_id           = rsp_item_ff.rom_id;

`ifndef SYNTHESIS
   // A decided beat without a result leaves the result register empty.
   assert property (@(posedge clock) disable iff (reset)
      advance && !core_has_rsp |=> !rsp_valid_ff)
      else $error("result register not empty after a silent beat");

   // A decided beat with a result is always offered next cycle.
   assert property (@(posedge clock) disable iff (reset)
      advance && core_has_rsp |=> rsp_valid_ff)
      else $error("result beat lost");

   // The input side stalls only while a beat is held in the input register.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("stall without a held beat");

   // ROM and discrepancy are shown only on the beat that ends a pass.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_DONE) |->
         (rsp_rom_id == '0) && (rsp_next_discrepancy == '0))
      else $error("pass fields set outside a done beat");
`endif

endmodule

`default_nettype wire
